// ----- src/ile_pkg.sv -----
`timescale 1ns / 1ps

package ile_pkg;

  // Width of a cell index broadcast; covers the largest supported list.
  localparam int IDX_W = 10;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_MODIFY = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_INS  = 3'd1,
    CELL_DEL  = 3'd2,
    CELL_MOD  = 3'd3,
    CELL_FIND = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [7:0]  position;
    logic signed [31:0] data_value;
  } cmd_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [6:0]         count;
  } res_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

// ----- src/ile_cell.sv -----
`timescale 1ns / 1ps

module ile_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  ile_pkg::cell_ctl_t ctl,
  input  logic signed [31:0] left_value,
  input  logic signed [31:0] right_value,
  output logic signed [31:0] value,
  output logic signed [31:0] rd_value
);
  import ile_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_INS: begin
        if (MY_IDX > ctl.idx) begin
          value <= left_value;
        end else if (MY_IDX == ctl.idx) begin
          value <= ctl.value;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= ctl.idx) begin
          value <= right_value;
        end
      end
      CELL_MOD: begin
        if (MY_IDX == ctl.idx) begin
          value <= ctl.value;
        end
      end
      default: begin
      end
    endcase
  end

  // Masked read: only the addressed cell returns its element.
  always_ff @(posedge clk) begin
    if (ctl.op == CELL_FIND && MY_IDX == ctl.idx) begin
      rd_value <= value;
    end else begin
      rd_value <= '0;
    end
  end

endmodule

// ----- src/indexed_list_engine.sv -----
`timescale 1ns / 1ps
// Each item passes through accept, cell update, read gather and emit in turn;
// a new item is taken only once the last one has been emitted (cmd_stall).
// The count check and the shift of the cell row happen in the same cycle;
// the find read is gathered through a registered OR tree of groups of 8 cells.
// Reset (rst, synchronous, active high) empties the list and drops any result;
// element contents are not cleared.

module indexed_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  ile_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output ile_pkg::res_t res
);
  import ile_pkg::*;

  // count holds 0..CAPACITY
  localparam int CW = $clog2(CAPACITY + 1);
  // signed compare width for position against count
  localparam int SW = (CW + 1 > 9) ? CW + 1 : 9;
  // read gather groups
  localparam int GS = 8;
  localparam int NG = (CAPACITY + GS - 1) / GS;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_REDUCE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t        state;
  state_t        state_next;
  cmd_t          cmd_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_next;
  logic          ok_r;
  logic          ok_next;
  cell_ctl_t     ctl;

  logic signed [31:0] cell_value [CAPACITY];
  logic signed [31:0] cell_rd    [CAPACITY];
  logic signed [31:0] grp        [NG];
  logic signed [31:0] gather;

  logic signed [SW-1:0] pos_w;
  logic signed [SW-1:0] cnt_w;
  logic                 in_range;

  assign cmd_stall = (state != ST_IDLE);

  // Position checks against the count before the operation.
  assign pos_w    = SW'(cmd_r.position);
  assign cnt_w    = $signed(SW'({1'b0, count_r}));
  assign in_range = (pos_w >= 0) && (pos_w < cnt_w);

  always_comb begin
    ok_next    = 1'b0;
    count_next = count_r;
    ctl.op     = CELL_HOLD;
    ctl.idx    = IDX_W'(pos_w);
    ctl.value  = cmd_r.data_value;
    if (state == ST_EXEC) begin
      unique case (cmd_r.command)
        CMD_INSERT: begin
          // new element lands just after the given position
          ctl.idx = IDX_W'(pos_w + SW'(1));
          if (pos_w >= -1 && pos_w < cnt_w && count_r < CW'(CAPACITY)) begin
            ok_next    = 1'b1;
            count_next = count_r + CW'(1);
            ctl.op     = CELL_INS;
          end
        end
        CMD_DELETE: begin
          if (in_range) begin
            ok_next    = 1'b1;
            count_next = count_r - CW'(1);
            ctl.op     = CELL_DEL;
          end
        end
        CMD_MODIFY: begin
          if (in_range) begin
            ok_next = 1'b1;
            ctl.op  = CELL_MOD;
          end
        end
        CMD_FIND: begin
          if (in_range) begin
            ok_next = 1'b1;
            ctl.op  = CELL_FIND;
          end
        end
        CMD_CLEAR: begin
          ok_next    = 1'b1;
          count_next = '0;
        end
        default: begin
          // unused codes: rejected, nothing changes
        end
      endcase
    end
  end

  // The cell row. Cell 0 never takes from the left; the last cell's right
  // neighbor is itself (its slot becomes unused on delete).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = cell_value[i];
    end else begin : g_mid_r
      assign right_in = cell_value[i+1];
    end
    ile_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_value (left_in),
      .right_value(right_in),
      .value      (cell_value[i]),
      .rd_value   (cell_rd[i])
    );
  end

  // First gather level: OR of the masked reads in each group of cells.
  // Loaded once per item and held while the result waits to leave.
  always_ff @(posedge clk) begin
    if (state == ST_REDUCE) begin
      for (int g = 0; g < NG; g++) begin
        logic signed [31:0] acc;
        acc = '0;
        for (int j = 0; j < GS; j++) begin
          if (g * GS + j < CAPACITY) begin
            acc = acc | cell_rd[g * GS + j];
          end
        end
        grp[g] <= acc;
      end
    end
  end

  always_comb begin
    gather = '0;
    for (int g = 0; g < NG; g++) begin
      gather = gather | grp[g];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // wait for the output register to free up
        if (!res_valid || !res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count_r   <= '0;
      ok_r      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EXEC) begin
        count_r <= count_next;
        ok_r    <= ok_next;
      end
      if (state == ST_EMIT && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_r <= cmd;
    end
    if (state == ST_EMIT && (!res_valid || !res_stall)) begin
      res.ok         <= ok_r;
      res.read_value <= gather;
      res.count      <= 7'(count_r);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> (state == ST_EXEC))
    else $error("accepted item did not enter execution");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_EMIT))
    else $error("result appeared without an emit cycle");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && !ok_next) |=> (count_r == $past(count_r)))
    else $error("rejected command changed the count");
`endif

endmodule

// ----- tb/indexed_list_engine_test.sv -----
`timescale 1ns / 1ps

module indexed_list_engine_test;
  import ile_pkg::*;

  localparam int CAPACITY = 64;
  localparam int ITEMS_PER_PHASE = 484;   // three random phases, ~1450 items
  localparam int IDLE_LIMIT = 2000;       // cycles with no accept on either side
  localparam int TAIL_CYCLES = 8;         // idle tail after the last result

  // Command codes the block does not decode.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  indexed_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow list: our own copy of the element row and its length.
  // ---------------------------------------------------------------------------
  logic signed [31:0] list_elems [CAPACITY];
  int                 list_len = 0;

  res_t pending_results [$];   // expected results, oldest first
  int   mismatch_count = 0;
  res_t head_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Random mix state: alternate between growing and shrinking the list so
  // both the full list and the empty list are reached again and again.
  bit growing = 1'b1;
  int mode_left = 150;

  // Directed table; rows marked typed carry a hand-written result.
  typedef struct {
    cmd_t item;
    bit   typed;
    res_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // Apply one command to the shadow list and return the result it gives.
  function automatic res_t apply_to_list(cmd_t c);
    res_t r;
    int   p;
    int   k;
    r = '0;
    p = int'($signed(c.position));
    case (c.command)
      CMD_INSERT: begin
        if (p >= -1 && p <= list_len - 1 && list_len < CAPACITY) begin
          // new element lands at p+1, the tail shifts up by one
          for (k = list_len; k > p + 1; k--) list_elems[k] = list_elems[k-1];
          list_elems[p+1] = c.data_value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (p >= 0 && p <= list_len - 1) begin
          for (k = p; k < list_len - 1; k++) list_elems[k] = list_elems[k+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      CMD_MODIFY: begin
        if (p >= 0 && p <= list_len - 1) begin
          list_elems[p] = c.data_value;
          r.ok = 1'b1;
        end
      end
      CMD_FIND: begin
        if (p >= 0 && p <= list_len - 1) begin
          r.read_value = list_elems[p];
          r.ok = 1'b1;
        end
      end
      CMD_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      default: ;  // undecoded codes leave everything alone
    endcase
    r.count = 7'(list_len);
    return r;
  endfunction

  function automatic cmd_t make_random_item();
    cmd_t c;
    int   r;
    int   lo;
    int   hi;
    int   p;
    r = int'($urandom_range(99));
    if (mode_left == 0) begin
      growing = !growing;
      mode_left = int'($urandom_range(250, 120));
    end
    mode_left--;
    if (growing) begin
      if (r < 55) c.command = CMD_INSERT;
      else if (r < 65) c.command = CMD_DELETE;
      else if (r < 77) c.command = CMD_MODIFY;
      else if (r < 96) c.command = CMD_FIND;
      else c.command = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    end else begin
      if (r < 15) c.command = CMD_INSERT;
      else if (r < 55) c.command = CMD_DELETE;
      else if (r < 70) c.command = CMD_MODIFY;
      else if (r < 93) c.command = CMD_FIND;
      else if (r < 97) c.command = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      else c.command = CMD_CLEAR;
    end

    // Position: mostly legal with extra weight on the ends, some just past
    // the legal range, and some raw noise over all 8 bits.
    lo = (c.command == CMD_INSERT) ? -1 : 0;
    hi = list_len - 1;
    r = int'($urandom_range(99));
    if (r < 80 && hi >= lo) begin
      case ($urandom_range(3))
        0:       p = lo;
        1:       p = hi;
        default: p = int'($urandom_range(hi - lo)) + lo;
      endcase
      c.position = 8'(p);
    end else if (r < 90) begin
      c.position = $urandom_range(1) ? 8'(hi + 1) : 8'(lo - 1);
    end else begin
      c.position = 8'($urandom);
    end

    case ($urandom_range(9))
      0:       c.data_value = 32'sh7fff_ffff;
      1:       c.data_value = 32'sh8000_0000;
      2:       c.data_value = '0;
      3:       c.data_value = '1;
      default: c.data_value = $urandom;
    endcase
    return c;
  endfunction

  task automatic add_row(input logic [2:0] c, input int p, input logic [31:0] v,
                         input bit typed, input bit ok, input logic [31:0] rd,
                         input int cnt);
    dir_row_t row;
    row.item.command = c;
    row.item.position = 8'(p);
    row.item.data_value = v;
    row.typed = typed;
    row.want.ok = ok;
    row.want.read_value = rd;
    row.want.count = 7'(cnt);
    dir_rows.push_back(row);
  endtask

  // Offer one item, with random idle cycles in front, and record its
  // expected result once the block takes it.
  task automatic send_item(input cmd_t item, input bit typed, input res_t want);
    res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= item;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predicted = apply_to_list(item);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Hold the sender off until every expected result is back.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, then check each accepted result in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: ok=%0d read_value=%h count=%0d",
               res.ok, res.read_value, res.count);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (res.ok !== head_result.ok) begin
          $error("ok: expected %0d, got %0d", head_result.ok, res.ok);
          mismatch_count++;
        end
        if (res.read_value !== head_result.read_value) begin
          $error("read_value: expected %h, got %h",
                 head_result.read_value, res.read_value);
          mismatch_count++;
        end
        if (res.count !== head_result.count) begin
          $error("count: expected %0d, got %0d", head_result.count, res.count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: no accept on either channel for too long means a hang.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int ph;
    int n;

    // Empty list: every positional command is rejected.
    add_row(CMD_FIND,   0, 32'd0, 1, 0, 32'd0, 0);
    add_row(CMD_DELETE, 0, 32'd0, 1, 0, 32'd0, 0);
    add_row(CMD_MODIFY, 0, 32'd5, 1, 0, 32'd0, 0);
    add_row(CMD_INSERT, 0, 32'd9, 1, 0, 32'd0, 0);   // only head insert is legal
    // Head insert, then insert after the head; value extremes.
    add_row(CMD_INSERT, -1, 32'h7fff_ffff, 1, 1, 32'd0, 1);
    add_row(CMD_INSERT,  0, 32'h8000_0000, 1, 1, 32'd0, 2);
    add_row(CMD_FIND,    0, 32'd0, 1, 1, 32'h7fff_ffff, 2);
    add_row(CMD_FIND,    1, 32'd0, 1, 1, 32'h8000_0000, 2);
    add_row(CMD_FIND,    2, 32'd0, 1, 0, 32'd0, 2);
    // Position field extremes and bad negatives.
    add_row(CMD_INSERT,  127, 32'd1, 1, 0, 32'd0, 2);
    add_row(CMD_INSERT, -128, 32'd1, 1, 0, 32'd0, 2);
    add_row(CMD_DELETE,   -1, 32'd0, 1, 0, 32'd0, 2);
    add_row(CMD_FIND,     -1, 32'd0, 1, 0, 32'd0, 2);
    // Undecoded command codes.
    add_row(CMD_UNUSED_LO,       0, 32'hffff_ffff, 1, 0, 32'd0, 2);
    add_row(CMD_UNUSED_LO + 3'd1, 0, 32'hffff_ffff, 1, 0, 32'd0, 2);
    add_row(CMD_UNUSED_HI,       0, 32'hffff_ffff, 1, 0, 32'd0, 2);
    // Shifts in both directions, checked by the shadow list.
    add_row(CMD_INSERT, -1, 32'd0,         0, 0, 32'd0, 0);
    add_row(CMD_INSERT,  2, 32'hffff_ffff, 0, 0, 32'd0, 0);
    add_row(CMD_MODIFY,  1, 32'h1234_5678, 0, 0, 32'd0, 0);
    add_row(CMD_DELETE,  0, 32'd0,         0, 0, 32'd0, 0);
    add_row(CMD_FIND,    0, 32'd0,         0, 0, 32'd0, 0);
    add_row(CMD_DELETE,  2, 32'd0,         0, 0, 32'd0, 0);
    add_row(CMD_FIND,    1, 32'd0,         0, 0, 32'd0, 0);
    // Clear always succeeds, also on an empty list.
    add_row(CMD_CLEAR,   0, 32'd0, 1, 1, 32'd0, 0);
    add_row(CMD_CLEAR,  -1, 32'd0, 1, 1, 32'd0, 0);
    add_row(CMD_FIND,    0, 32'd0, 1, 0, 32'd0, 0);

    send_idle_pct = 18;
    recv_idle_pct = 59;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    // Random phases: sender-light/receiver-heavy, the reverse, then no idling.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 18; recv_idle_pct = 59; end
        1:       begin send_idle_pct = 59; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_item(make_random_item(), 1'b0, '0);
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ile_pkg.sv
src/ile_cell.sv
src/indexed_list_engine.sv
tb/indexed_list_engine_test.sv
